[rtl/edf_pkg.sv]
// ============================================================================
// edf_pkg
// Shared types and constants for the EDF task scheduler.
// ============================================================================
package edf_pkg;

    localparam int MAX_TASKS = 16;
    localparam int SLOT_W    = $clog2(MAX_TASKS);
    localparam int ID_W      = 5;
    localparam logic [31:0] MIN_TIMEOUT_RESET = 32'd5000;

    // one task entry: key and period kept together in one memory word
    localparam int ENTRY_W = 96;

    typedef enum logic [2:0] {
        FN_ADD      = 3'd0,
        FN_START    = 3'd1,
        FN_TICK     = 3'd2,
        FN_COMPLETE = 3'd3,
        FN_REMOVE   = 3'd4,
        FN_RESET    = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_NOT_RUN = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ACT_IDLE    = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_RESUME  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_SCAN,
        S_SCAN2,
        S_PICK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] now;
        logic [31:0] task_period;
        logic [4:0]  task_id;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  chosen_task;
        logic [1:0]  action;
        logic [63:0] timeout;
        logic        timeout_valid;
    } t_out;

endpackage

[rtl/edf_ram.sv]
// ============================================================================
// edf_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ============================================================================
module edf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/edf_task_scheduler.sv]
// ============================================================================
// edf_task_scheduler
// Earliest-deadline-first scheduler over a table of periodic tasks.
// ============================================================================
// Add/complete/remove/reset go from accept through S_RD and S_OUT to result.
// Start and tick sweep the task memory one slot per cycle in S_SCAN, since
// the key memory has a single read port, then pass S_SCAN2 and S_PICK.
// One item is in flight at a time; the result register frees the input.
// Reset clears the flag bits and running task, sets next id to 1; min_timeout = 5000.
// The key/period memory is not cleared: add writes an entry before use.
module edf_task_scheduler (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  edf_pkg::t_in         i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output edf_pkg::t_out        o_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [31:0]          i_cfg_data
);
    import edf_pkg::*;

    t_state r_state, n_state;
    t_in    r_in, n_in;
    t_out   r_out, n_out;
    logic   r_ovalid, n_ovalid;
    logic [31:0] r_min_to;
    logic [MAX_TASKS-1:0] r_used, n_used, r_rdy, n_rdy, r_await, n_await;
    logic [ID_W-1:0] r_next_id, n_next_id, r_run, n_run;
    logic [SLOT_W:0] r_idx, n_idx;
    logic [SLOT_W-1:0] rd_slot, r_rd_slot, n_rd_slot;
    logic            r_rd_live, n_rd_live;
    logic            r_hb, n_hb, r_hn, n_hn;
    logic [63:0]     r_bk, n_bk, r_nr, n_nr;
    logic [SLOT_W-1:0] r_best, n_best;

    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [ENTRY_W-1:0] wdata, rdata;
    logic [63:0] key, newkey, d;
    logic [31:0] per;
    logic        rel, ready_now;
    logic [SLOT_W-1:0] tslot;
    logic        tid_ok;

    edf_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_TASKS)) u_keys (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(rd_slot), .o_rdata(rdata)
    );

    assign o_stall     = (r_state != S_IDLE) || (r_ovalid && i_stall);
    assign o_valid     = r_ovalid;
    assign o_data      = r_out;
    assign o_cfg_ready = 1'b1;

    assign key    = rdata[95:32];
    assign per    = rdata[31:0];
    assign newkey = r_in.now + {32'd0, per};
    assign tslot  = r_in.task_id[SLOT_W-1:0] - 1'b1;
    assign tid_ok = (r_in.task_id >= ID_W'(1)) && (r_in.task_id <= ID_W'(MAX_TASKS))
                    && r_used[tslot];
    assign rd_slot = r_idx[SLOT_W-1:0];
    assign d = r_nr - r_in.now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_min_to  <= MIN_TIMEOUT_RESET;
            r_used    <= '0;
            r_rdy     <= '0;
            r_await   <= '0;
            r_next_id <= ID_W'(1);
            r_run     <= '0;
            r_rd_live <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ovalid  <= n_ovalid;
            r_used    <= n_used;
            r_rdy     <= n_rdy;
            r_await   <= n_await;
            r_next_id <= n_next_id;
            r_run     <= n_run;
            r_rd_live <= n_rd_live;
            if (i_cfg_valid) begin
                r_min_to <= i_cfg_data;
            end
        end
        r_in      <= n_in;
        r_out     <= n_out;
        r_idx     <= n_idx;
        r_rd_slot <= n_rd_slot;
        r_hb      <= n_hb;
        r_hn      <= n_hn;
        r_bk      <= n_bk;
        r_nr      <= n_nr;
        r_best    <= n_best;
    end

    always_comb begin
        n_state   = r_state;
        n_in      = r_in;
        n_out     = r_out;
        n_ovalid  = r_ovalid && i_stall;
        n_used    = r_used;
        n_rdy     = r_rdy;
        n_await   = r_await;
        n_next_id = r_next_id;
        n_run     = r_run;
        n_idx     = r_idx;
        n_rd_slot = rd_slot;
        n_rd_live = 1'b0;
        n_hb      = r_hb;
        n_hn      = r_hn;
        n_bk      = r_bk;
        n_nr      = r_nr;
        n_best    = r_best;
        we        = 1'b0;
        waddr     = r_rd_slot;
        wdata     = {newkey, per};
        rel       = 1'b0;
        ready_now = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid && !o_stall) begin
                    n_in    = i_data;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_out   = '0;
                n_idx   = '0;
                n_hb    = 1'b0;
                n_hn    = 1'b0;
                n_state = S_OUT;
                case (r_in.func)
                    FN_ADD: begin
                        if (r_next_id > ID_W'(MAX_TASKS)) begin
                            n_out.status = ST_FULL;
                        end else begin
                            we    = 1'b1;
                            waddr = SLOT_W'(r_next_id - 1'b1);
                            wdata = {59'd0, r_next_id, r_in.task_period};
                            n_used[waddr]  = 1'b1;
                            n_rdy[waddr]   = 1'b0;
                            n_await[waddr] = 1'b1;
                            n_out.chosen_task = r_next_id;
                            n_next_id = r_next_id + 1'b1;
                        end
                    end
                    FN_START, FN_TICK: begin
                        n_state = S_SCAN;
                    end
                    FN_COMPLETE: begin
                        if (!tid_ok) begin
                            n_out.status = ST_UNKNOWN;
                        end else if (r_run != r_in.task_id || !r_rdy[tslot]) begin
                            n_out.status = ST_NOT_RUN;
                        end else begin
                            n_rdy[tslot]   = 1'b0;
                            n_await[tslot] = 1'b1;
                            n_run          = '0;
                        end
                    end
                    FN_REMOVE: begin
                        if (!tid_ok) begin
                            n_out.status = ST_UNKNOWN;
                        end else begin
                            n_used[tslot]  = 1'b0;
                            n_rdy[tslot]   = 1'b0;
                            n_await[tslot] = 1'b0;
                            if (r_run == r_in.task_id) begin
                                n_run = '0;
                            end
                        end
                    end
                    FN_RESET: begin
                        n_used    = '0;
                        n_rdy     = '0;
                        n_await   = '0;
                        n_next_id = ID_W'(1);
                        n_run     = '0;
                    end
                    default: ;
                endcase
            end
            S_SCAN: begin
                // issue reads slot by slot; process the entry read last cycle
                if (r_idx < (SLOT_W+1)'(MAX_TASKS)) begin
                    n_rd_live = 1'b1;
                    n_rd_slot = rd_slot;
                    n_idx     = r_idx + 1'b1;
                end else begin
                    n_state = S_SCAN2;
                end
            end
            S_SCAN2: begin
                n_state = S_PICK;
            end
            default: ;
        endcase

        // entry returned by the memory: release, then on tick track minima
        if (r_rd_live && r_used[r_rd_slot]) begin
            ready_now = r_rdy[r_rd_slot];
            if (!ready_now && (r_in.func == FN_START || key <= r_in.now)) begin
                rel = 1'b1;
            end
            if (rel) begin
                we = 1'b1;
                n_rdy[r_rd_slot] = 1'b1;
            end
            if (r_in.func == FN_TICK) begin
                if (rel || ready_now) begin
                    if (!r_hb || (rel ? newkey : key) < r_bk) begin
                        n_hb   = 1'b1;
                        n_bk   = rel ? newkey : key;
                        n_best = r_rd_slot;
                    end
                end else if (!r_hn || key < r_nr) begin
                    n_hn = 1'b1;
                    n_nr = key;
                end
            end
        end

        if (r_state == S_PICK) begin
            n_state = S_OUT;
            if (r_in.func == FN_TICK) begin
                if (r_hn) begin
                    n_out.timeout_valid = 1'b1;
                    n_out.timeout = (d < {32'd0, r_min_to}) ? {32'd0, r_min_to} : d;
                end
                if (r_hb) begin
                    n_out.chosen_task = ID_W'(r_best) + 1'b1;
                    n_run = ID_W'(r_best) + 1'b1;
                    if (r_await[r_best]) begin
                        n_out.action = ACT_RELEASE;
                        n_await[r_best] = 1'b0;
                    end else begin
                        n_out.action = ACT_RESUME;
                    end
                end else begin
                    n_run = '0;
                end
            end
        end

        if (r_state == S_OUT && !(r_ovalid && i_stall)) begin
            n_ovalid = 1'b1;
            n_state  = S_IDLE;
        end
    end
endmodule
